### hdl/midpoint_ellipse_rasterizer_unit_assert.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that holds at every edge outside reset.
`define MERA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define MERA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MERA_ASSERT(label, clk, rst, prop, msg)
`define MERA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/mera_pkg.sv
package mera_pkg;

   localparam int COORD_BITS_DEFAULT = 10;
   localparam int PIX_BITS           = 12;
   localparam int QUAD_BITS          = 2;

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // symmetric copies of the current point
   localparam logic [QUAD_BITS-1:0] QUAD_POS_POS = 2'd0;
   localparam logic [QUAD_BITS-1:0] QUAD_NEG_NEG = 2'd1;
   localparam logic [QUAD_BITS-1:0] QUAD_POS_NEG = 2'd2;
   localparam logic [QUAD_BITS-1:0] QUAD_NEG_POS = 2'd3;

   // operand width of the shared multiplier for the default coordinate width
   localparam int MUL_BITS_DEFAULT = 2 * COORD_BITS_DEFAULT + 4;

endpackage

### hdl/mera_mul.sv
module mera_mul #(
   parameter int WIDTH = mera_pkg::MUL_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   output logic [2*WIDTH-1:0]   product
);

   logic [2*WIDTH-1:0] product_in;
   logic [2*WIDTH-1:0] product_ff;

   always_comb begin
      product_in = (2*WIDTH)'(op_a) * (2*WIDTH)'(op_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### hdl/midpoint_ellipse_rasterizer_unit.sv
// Axis-aligned ellipse rasterizer, two-region midpoint scheme with the decision
// value held times four so every term is an exact integer. A start transaction
// (operation 0) latches both radii (zero reads as one) and the centre, gives no
// result and holds req_ready low while the squares and start terms are formed. Each step
// transaction (operation 1) returns the four mirrored pixels of the current
// point, one per cycle from a registered output while rsp_ready is high, then
// advances the point; the step that hands over from region one to region two
// also forms the region-two decision, and the last step's fourth pixel
// carries final_pixel and leaves the block idle. A step while idle gives
// nothing. Setup of the squares and of the region-two decision runs through a
// single registered multiplier, one product per cycle; the per-step update is
// additions only, in ST_ADV_POINT and then ST_ADV_DEC.
`include "midpoint_ellipse_rasterizer_unit_assert.svh"

module midpoint_ellipse_rasterizer_unit #(
   parameter int COORD_BITS = mera_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [COORD_BITS-1:0]               req_radius_x,
   input  logic [COORD_BITS-1:0]               req_radius_y,
   input  logic [COORD_BITS-1:0]               req_center_x,
   input  logic [COORD_BITS-1:0]               req_center_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mera_pkg::PIX_BITS-1:0] rsp_pixel_x,
   output logic signed [mera_pkg::PIX_BITS-1:0] rsp_pixel_y,
   output logic [mera_pkg::QUAD_BITS-1:0]      rsp_quadrant,
   output logic                                rsp_final_pixel
);

   localparam int PW  = COORD_BITS + 1;          // current point
   localparam int SQW = 2 * COORD_BITS;          // radius squares
   localparam int TW  = 3 * COORD_BITS;          // rx^2 * ry
   localparam int STW = 3 * COORD_BITS + 3;      // incremental terms
   localparam int MW  = 2 * COORD_BITS + 4;      // multiplier operands
   localparam int DW  = 2 * MW;                  // decision value
   localparam int OSW = (COORD_BITS + 2 > mera_pkg::PIX_BITS) ?
                        COORD_BITS + 2 : mera_pkg::PIX_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR_X,
      ST_SQR_Y,
      ST_MUL_T,
      ST_INIT,
      ST_EMIT,
      ST_ADV_POINT,
      ST_ADV_DEC,
      ST_R2_A,
      ST_R2_B,
      ST_R2_C,
      ST_R2_D,
      ST_R2_E,
      ST_R2_F
   } state_type;

   state_type                       state_ff, state_in;
   logic [COORD_BITS-1:0]           radius_x_ff, radius_x_in;
   logic [COORD_BITS-1:0]           radius_y_ff, radius_y_in;
   logic [COORD_BITS-1:0]           centre_x_ff, centre_x_in;
   logic [COORD_BITS-1:0]           centre_y_ff, centre_y_in;
   logic [SQW-1:0]                  rx2_ff, rx2_in;
   logic [SQW-1:0]                  ry2_ff, ry2_in;
   logic [PW-1:0]                   x_ff, x_in;
   logic [PW-1:0]                   y_ff, y_in;
   logic [STW-1:0]                  dx_ff, dx_in;
   logic [STW-1:0]                  dy_ff, dy_in;
   logic [DW-1:0]                   dec_ff, dec_in;
   logic [MW-1:0]                   tmp_ff, tmp_in;
   logic                            region2_ff, region2_in;
   logic                            active_ff, active_in;
   logic                            out_valid_ff, out_valid_in;
   logic [mera_pkg::PIX_BITS-1:0]   pix_x_ff, pix_x_in;
   logic [mera_pkg::PIX_BITS-1:0]   pix_y_ff, pix_y_in;
   logic [mera_pkg::QUAD_BITS-1:0]  quad_ff, quad_in;
   logic                            final_ff, final_in;

   logic [MW-1:0]                   mul_a, mul_b;
   logic [DW-1:0]                   prod;

   logic                            req_take;
   logic                            rsp_take;
   logic                            dec_neg, dec_pos;
   logic                            step_x, step_y;
   logic [COORD_BITS-1:0]           rx_eff, ry_eff;
   logic [PW-1:0]                   y_less_one;
   logic [DW-1:0]                   dec_inc;
   logic                            x_neg, y_neg;
   logic [OSW-1:0]                  sum_x, sum_y;

   mera_mul #(
      .WIDTH (MW)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = out_valid_ff && rsp_ready;

   assign dec_neg = dec_ff[DW-1];
   assign dec_pos = !dec_neg && (dec_ff != '0);
   // region one always steps x, region two always steps y
   assign step_x  = region2_ff ? !dec_pos : 1'b1;
   assign step_y  = region2_ff ? 1'b1 : !dec_neg;

   assign rx_eff     = (req_radius_x == '0) ? COORD_BITS'(1) : req_radius_x;
   assign ry_eff     = (req_radius_y == '0) ? COORD_BITS'(1) : req_radius_y;
   assign y_less_one = (y_ff == '0) ? PW'(1) : y_ff - PW'(1);

   assign dec_inc = (step_x ? DW'(dx_ff) : '0) - (step_y ? DW'(dy_ff) : '0)
                    + (region2_ff ? DW'(rx2_ff) : DW'(ry2_ff));

   // pixel for the copy about to be loaded into the output register
   assign x_neg = (quad_in == mera_pkg::QUAD_NEG_NEG) || (quad_in == mera_pkg::QUAD_NEG_POS);
   assign y_neg = (quad_in == mera_pkg::QUAD_NEG_NEG) || (quad_in == mera_pkg::QUAD_POS_NEG);
   assign sum_x = x_neg ? OSW'(centre_x_ff) - OSW'(x_ff) : OSW'(centre_x_ff) + OSW'(x_ff);
   assign sum_y = y_neg ? OSW'(centre_y_ff) - OSW'(y_ff) : OSW'(centre_y_ff) + OSW'(y_ff);

   always_comb begin
      state_in     = state_ff;
      radius_x_in  = radius_x_ff;
      radius_y_in  = radius_y_ff;
      centre_x_in  = centre_x_ff;
      centre_y_in  = centre_y_ff;
      rx2_in       = rx2_ff;
      ry2_in       = ry2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dec_in       = dec_ff;
      tmp_in       = tmp_ff;
      region2_in   = region2_ff;
      active_in    = active_ff;
      out_valid_in = out_valid_ff;
      quad_in      = quad_ff;
      final_in     = final_ff;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_operation == mera_pkg::OP_START) begin
                  radius_x_in = rx_eff;
                  radius_y_in = ry_eff;
                  centre_x_in = req_center_x;
                  centre_y_in = req_center_y;
                  state_in    = ST_SQR_X;
               end else if (active_ff) begin
                  out_valid_in = 1'b1;
                  quad_in      = mera_pkg::QUAD_POS_POS;
                  final_in     = 1'b0;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_SQR_X: begin
            mul_a    = MW'(radius_x_ff);
            mul_b    = MW'(radius_x_ff);
            state_in = ST_SQR_Y;
         end
         ST_SQR_Y: begin
            rx2_in   = prod[SQW-1:0];
            mul_a    = MW'(radius_y_ff);
            mul_b    = MW'(radius_y_ff);
            state_in = ST_MUL_T;
         end
         ST_MUL_T: begin
            ry2_in   = prod[SQW-1:0];
            mul_a    = MW'(rx2_ff);
            mul_b    = MW'(radius_y_ff);
            state_in = ST_INIT;
         end
         ST_INIT: begin
            x_in       = '0;
            y_in       = PW'(radius_y_ff);
            dx_in      = '0;
            dy_in      = STW'(prod[TW-1:0]) << 1;
            dec_in     = (DW'(ry2_ff) << 2) - (DW'(prod[TW-1:0]) << 2) + DW'(rx2_ff);
            region2_in = 1'b0;
            active_in  = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_take) begin
               if (quad_ff == mera_pkg::QUAD_NEG_POS) begin
                  out_valid_in = 1'b0;
                  if (y_ff == '0) begin
                     active_in = 1'b0;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in  = ST_ADV_POINT;
                  end
               end else begin
                  quad_in  = quad_ff + mera_pkg::QUAD_BITS'(1);
                  final_in = (quad_in == mera_pkg::QUAD_NEG_POS) && (y_ff == '0);
               end
            end
         end
         ST_ADV_POINT: begin
            if (step_x) begin
               x_in  = x_ff + PW'(1);
               dx_in = dx_ff + (STW'(ry2_ff) << 1);
            end
            if (step_y) begin
               y_in  = y_ff - PW'(1);
               dy_in = dy_ff - (STW'(rx2_ff) << 1);
            end
            state_in = ST_ADV_DEC;
         end
         ST_ADV_DEC: begin
            // decision still holds its pre-step value, so step_x/step_y repeat
            dec_in = dec_ff + (dec_inc << 2);
            if (!region2_ff && (dx_ff >= dy_ff)) begin
               state_in = ST_R2_A;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_R2_A: begin
            mul_a    = MW'({x_ff, 1'b1});
            mul_b    = MW'({x_ff, 1'b1});
            state_in = ST_R2_B;
         end
         ST_R2_B: begin
            tmp_in   = prod[MW-1:0];
            mul_a    = MW'(y_less_one);
            mul_b    = MW'(y_less_one);
            state_in = ST_R2_C;
         end
         ST_R2_C: begin
            tmp_in   = prod[MW-1:0];
            mul_a    = MW'(ry2_ff);
            mul_b    = tmp_ff;
            state_in = ST_R2_D;
         end
         ST_R2_D: begin
            dec_in   = prod;
            mul_a    = MW'(rx2_ff);
            mul_b    = tmp_ff;
            state_in = ST_R2_E;
         end
         ST_R2_E: begin
            dec_in   = dec_ff + (prod << 2);
            mul_a    = MW'(rx2_ff);
            mul_b    = MW'(ry2_ff);
            state_in = ST_R2_F;
         end
         ST_R2_F: begin
            dec_in     = dec_ff - (prod << 2);
            region2_in = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pix_x_in = sum_x[mera_pkg::PIX_BITS-1:0];
      pix_y_in = sum_y[mera_pkg::PIX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         region2_ff   <= 1'b0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         region2_ff   <= region2_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      radius_x_ff <= radius_x_in;
      radius_y_ff <= radius_y_in;
      centre_x_ff <= centre_x_in;
      centre_y_ff <= centre_y_in;
      rx2_ff      <= rx2_in;
      ry2_ff      <= ry2_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dec_ff      <= dec_in;
      tmp_ff      <= tmp_in;
      quad_ff     <= quad_in;
      final_ff    <= final_in;
      // hold the pixel unless a new copy is being loaded
      if (out_valid_in && (!out_valid_ff || rsp_take)) begin
         pix_x_ff <= pix_x_in;
         pix_y_ff <= pix_y_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_quadrant    = quad_ff;
   assign rsp_final_pixel = final_ff;

   `MERA_ASSERT(a_no_accept_while_emitting, clock, reset, !(req_ready && rsp_valid), "input accepted while pixels pending")
   `MERA_ASSERT(a_final_on_last_copy, clock, reset, (rsp_valid && rsp_final_pixel) |-> (rsp_quadrant == mera_pkg::QUAD_NEG_POS), "final pixel flagged on wrong copy")
   `MERA_ASSERT_NEXT(a_idle_after_final, clock, reset, rsp_valid && rsp_ready && rsp_final_pixel, !active_ff && req_ready, "drawing still active after final pixel")
   `MERA_ASSERT(a_region_one_order, clock, reset, (state_ff == ST_IDLE && active_ff && !region2_ff) |-> (dx_ff < dy_ff), "region one left without handover")

endmodule

### tb/sv/tb_midpoint_ellipse_rasterizer_unit.sv
module tb_midpoint_ellipse_rasterizer_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB          = mera_pkg::COORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int TARGET_LIVE = 165;

   typedef struct packed {
      logic [mera_pkg::PIX_BITS-1:0]  px;
      logic [mera_pkg::PIX_BITS-1:0]  py;
      logic [mera_pkg::QUAD_BITS-1:0] quad;
      logic                           fin;
   } pixel_type;

   class pixel_scoreboard;
      pixel_type   expected_pixels[$];
      int unsigned errors, n_starts, n_steps, n_pixels, n_ellipses;
      logic [31:0] cur_x, cur_y;
      logic [63:0] inc_x, inc_y, decision4, rx_sq, ry_sq;
      logic [11:0] ctr_x, ctr_y;
      bit          region_two, drawing;

      function new();
         errors     = 0;
         n_starts   = 0;
         n_steps    = 0;
         n_pixels   = 0;
         n_ellipses = 0;
         cur_x      = '0;
         cur_y      = '0;
         inc_x      = '0;
         inc_y      = '0;
         decision4  = '0;
         rx_sq      = '0;
         ry_sq      = '0;
         ctr_x      = '0;
         ctr_y      = '0;
         region_two = 0;
         drawing    = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Predict the pixels of one accepted transaction and advance the point.
      function void note_request(logic op, logic [CB-1:0] rx_in, logic [CB-1:0] ry_in,
                                 logic [CB-1:0] cx_in, logic [CB-1:0] cy_in);
         logic [63:0] rx, ry, two_x1, ym1;
         logic [11:0] xp, xn, yp, yn;
         logic [31:0] x, y;
         bit          last;
         if (op == mera_pkg::OP_START) begin
            // a zero radius reads as one
            rx         = (rx_in == 0) ? 64'd1 : 64'(rx_in);
            ry         = (ry_in == 0) ? 64'd1 : 64'(ry_in);
            rx_sq      = rx * rx;
            ry_sq      = ry * ry;
            ctr_x      = 12'(cx_in);
            ctr_y      = 12'(cy_in);
            cur_x      = '0;
            cur_y      = 32'(ry);
            inc_x      = '0;
            inc_y      = 64'd2 * rx_sq * ry;
            decision4  = 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
            region_two = 0;
            drawing    = 1;
            n_starts++;
            return;
         end
         if (!drawing)
            return;
         n_steps++;
         x    = cur_x;
         y    = cur_y;
         last = (y == 0);
         xp   = ctr_x + x[11:0];
         xn   = ctr_x - x[11:0];
         yp   = ctr_y + y[11:0];
         yn   = ctr_y - y[11:0];
         expected_pixels.push_back('{xp, yp, mera_pkg::QUAD_POS_POS, 1'b0});
         expected_pixels.push_back('{xn, yn, mera_pkg::QUAD_NEG_NEG, 1'b0});
         expected_pixels.push_back('{xp, yn, mera_pkg::QUAD_POS_NEG, 1'b0});
         expected_pixels.push_back('{xn, yp, mera_pkg::QUAD_NEG_POS, last});
         if (last) begin
            drawing = 0;
            n_ellipses++;
            return;
         end
         if (!region_two) begin
            cur_x = x + 1;
            inc_x = inc_x + 64'd2 * ry_sq;
            if (decision4[63]) begin
               decision4 = decision4 + 64'd4 * (inc_x + ry_sq);
            end else begin
               cur_y     = y - 1;
               inc_y     = inc_y - 64'd2 * rx_sq;
               decision4 = decision4 + 64'd4 * (inc_x - inc_y + ry_sq);
            end
            // hand over once the x term has caught up with the y term
            if (inc_x[62:0] >= inc_y[62:0]) begin
               two_x1     = 64'd2 * cur_x + 64'd1;
               ym1        = 64'(cur_y) - 64'd1;
               decision4  = ry_sq * two_x1 * two_x1 + 64'd4 * rx_sq * (ym1 * ym1)
                            - 64'd4 * rx_sq * ry_sq;
               region_two = 1;
            end
         end else begin
            cur_y = y - 1;
            inc_y = inc_y - 64'd2 * rx_sq;
            if (!decision4[63] && decision4 != 0) begin
               decision4 = decision4 + 64'd4 * (rx_sq - inc_y);
            end else begin
               cur_x     = x + 1;
               inc_x     = inc_x + 64'd2 * ry_sq;
               decision4 = decision4 + 64'd4 * (inc_x - inc_y + rx_sq);
            end
         end
      endfunction

      function void check_pixel(logic [11:0] px, logic [11:0] py, logic [1:0] q, logic fin);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel (%0d, %0d) quadrant %0d arrived with nothing predicted",
                   $signed(px), $signed(py), q);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         n_pixels++;
         if (px !== want.px) begin
            $error("pixel_x: expected %0d, got %0d", $signed(want.px), $signed(px));
            errors++;
         end
         if (py !== want.py) begin
            $error("pixel_y: expected %0d, got %0d", $signed(want.py), $signed(py));
            errors++;
         end
         if (q !== want.quad) begin
            $error("quadrant: expected %0d, got %0d", want.quad, q);
            errors++;
         end
         if (fin !== want.fin) begin
            $error("final_pixel: expected %0d, got %0d", want.fin, fin);
            errors++;
         end
      endfunction
   endclass

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic                                  req_operation = mera_pkg::OP_START;
   logic [CB-1:0]                         req_radius_x = '0;
   logic [CB-1:0]                         req_radius_y = '0;
   logic [CB-1:0]                         req_center_x = '0;
   logic [CB-1:0]                         req_center_y = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [mera_pkg::PIX_BITS-1:0]  rsp_pixel_x;
   logic signed [mera_pkg::PIX_BITS-1:0]  rsp_pixel_y;
   logic [mera_pkg::QUAD_BITS-1:0]        rsp_quadrant;
   logic                                  rsp_final_pixel;

   pixel_scoreboard sb;
   bit              no_idle  = 0;
   bit              hold_rsp = 0;
   int              cycle_count = 0;
   int              n_live   = 0;

   midpoint_ellipse_rasterizer_unit #(.COORD_BITS(CB)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_radius_x    (req_radius_x),
      .req_radius_y    (req_radius_y),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_quadrant    (rsp_quadrant),
      .rsp_final_pixel (rsp_final_pixel)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Note accepted requests before checking any result of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_operation, req_radius_x, req_radius_y,
                            req_center_x, req_center_y);
         if (rsp_valid && rsp_ready)
            sb.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_quadrant, rsp_final_pixel);
      end
   end

   // Result side: random stall before each pixel, one long hold on request.
   initial begin
      int stall;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(logic op, logic [CB-1:0] rx, logic [CB-1:0] ry,
                               logic [CB-1:0] cx, logic [CB-1:0] cy);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_radius_x  <= rx;
      req_radius_y  <= ry;
      req_center_x  <= cx;
      req_center_y  <= cy;
      do @(posedge clock); while (!req_ready);
   endtask

   // Step payload fields are ignored by the block, so fill them with noise.
   task automatic send_step();
      send_request(mera_pkg::OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                   CB'($urandom));
   endtask

   // One start then a number of steps; steps past the last pixel hit an idle block.
   task automatic draw_ellipse(int rx, int ry, int cx, int cy, int n_steps);
      int bound;
      bound = ((rx == 0) ? 1 : rx) + ((ry == 0) ? 1 : ry) + 1;
      send_request(mera_pkg::OP_START, CB'(rx), CB'(ry), CB'(cx), CB'(cy));
      n_live += 1 + ((n_steps < bound) ? n_steps : bound);
      repeat (n_steps) send_step();
   endtask

   // Step past the current edge first so its accepted transaction is already noted.
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int seq;
      int pick;
      int rx;
      int ry;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_step();
      draw_ellipse(0, 0, 0, 0, 4);
      draw_ellipse(1023, 1023, 1023, 1023, 3);
      draw_ellipse(1023, 1, 512, 0, 3);
      draw_ellipse(1, 1023, 0, 1023, 2);
      draw_ellipse(2, 3, 5, 7, 7);
      wait_drained();

      // random part
      seq = 0;
      while (n_live < TARGET_LIVE) begin
         seq++;
         no_idle = ($urandom_range(0, 4) == 0);
         if (seq == 3)
            hold_rsp = 1;
         if (seq == 8)
            wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 3)) send_step();
         end else if (pick < 14) begin
            // abandoned drawing: restart after few or no steps
            draw_ellipse($urandom_range(1, 14), $urandom_range(1, 14), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 2));
         end else if (pick < 24) begin
            draw_ellipse($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(1, 5));
         end else begin
            rx = $urandom_range(1, 14);
            ry = $urandom_range(1, 14);
            if ($urandom_range(0, 4) == 0)
               draw_ellipse(rx, ry, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(1, rx + ry));
            else
               draw_ellipse(rx, ry, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            rx + ry + 1 + $urandom_range(0, 1));
         end
      end
      no_idle = 0;
      req_valid <= 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d starts and %0d live steps; %0d pixels checked, %0d ellipses closed.",
               sb.n_starts, sb.n_steps, sb.n_pixels, sb.n_ellipses);
      $display("Mismatches: %0d, predictions left over: %0d", sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
